@@ src/btct_pkg.sv @@
// ----------------------------------------------------------------------------
// btct_pkg
// Shared sizes, types and helpers for the track curve tessellator.
// ----------------------------------------------------------------------------
package btct_pkg;

    localparam int COORD_BITS     = 24;
    localparam int STEP_FRAC_BITS = 10;
    // de casteljau with t below two grows a value at most 27-fold
    localparam int WIDE_BITS      = COORD_BITS + 5;
    localparam int T_BITS         = STEP_FRAC_BITS + 2;
    localparam int CFG_BITS       = STEP_FRAC_BITS + 1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [WIDE_BITS-1:0]  t_wide;
    typedef logic [T_BITS-1:0]            t_tval;
    typedef logic [CFG_BITS-1:0]          t_step;

    localparam t_tval T_ONE     = t_tval'(1) << STEP_FRAC_BITS;
    localparam int    MIN_STEP  = ((1 << STEP_FRAC_BITS) - 1) / 31 + 1;
    localparam t_step STEP_MIN  = t_step'(MIN_STEP);
    localparam t_step STEP_MAX  = t_step'(1) << STEP_FRAC_BITS;
    localparam t_step STEP_RST  = t_step'(1) << STEP_FRAC_BITS;

    localparam t_coord C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam t_coord C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    function automatic t_coord sat_wide(input t_wide v);
        t_coord r;
        if (v > t_wide'(C_MAX)) begin
            r = C_MAX;
        end else if (v < t_wide'(C_MIN)) begin
            r = C_MIN;
        end else begin
            r = t_coord'(v);
        end
        return r;
    endfunction

endpackage

@@ src/btct_if.sv @@
// ----------------------------------------------------------------------------
// btct interfaces
// Valid/ready channels for track points in and curve samples out.
// ----------------------------------------------------------------------------
interface btct_pt_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [btct_pkg::COORD_BITS-1:0] point_x;
    logic signed [btct_pkg::COORD_BITS-1:0] point_y;
    logic                                 last_point;
    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input last_point,
                    output ready);
endinterface

interface btct_cv_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [btct_pkg::COORD_BITS-1:0] curve_x;
    logic signed [btct_pkg::COORD_BITS-1:0] curve_y;
    logic                                 run_end;
    modport source (output valid, output curve_x, output curve_y, output run_end,
                    input ready);
    modport sink   (input valid, input curve_x, input curve_y, input run_end,
                    output ready);
endinterface

@@ src/bezier_track_curve_tessellator.sv @@
// ----------------------------------------------------------------------------
// bezier_track_curve_tessellator
// Each lerp passes through the ISSUE, WAIT and WB states; a coordinate takes 3
// lerps for a quadratic and 6 for a cubic, and each sample adds SAMP and EMIT.
// One point at a time; a point costs up to 32 cubic and 32 quadratic samples,
// all computed on the single shared lerp unit; EMIT waits for output room.
// Reset: synchronous active low; clears the point history and sets step to 1.0.
// ----------------------------------------------------------------------------
module bezier_track_curve_tessellator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    btct_pt_if.sink                    i_pt,
    btct_cv_if.source                  o_cv,
    input  logic                       i_cfg_we,
    input  logic [btct_pkg::CFG_BITS-1:0] i_cfg_data
);
    import btct_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CTL1   = 4'd1;
    localparam logic [3:0] ST_CTL2   = 4'd2;
    localparam logic [3:0] ST_SAMP   = 4'd3;
    localparam logic [3:0] ST_ISSUE  = 4'd4;
    localparam logic [3:0] ST_WAIT   = 4'd5;
    localparam logic [3:0] ST_WB     = 4'd6;
    localparam logic [3:0] ST_EMIT   = 4'd7;
    localparam logic [3:0] ST_FIN    = 4'd8;
    localparam logic [3:0] ST_EMIT_A = 4'd9;
    localparam logic [3:0] ST_EMIT_B = 4'd10;

    logic [3:0]  r_state;
    logic [1:0]  r_ps;
    t_step       r_cfg;
    t_step       r_step;
    t_coord      r_old_x, r_old_y, r_new_x, r_new_y, r_car_x, r_car_y;
    t_coord      r_in_x, r_in_y, r_cbc_x, r_cbc_y;
    t_coord      r_mab_x, r_mab_y, r_mbc_x, r_mbc_y;
    logic        r_last;
    t_coord      r_cpx [0:3];
    t_coord      r_cpy [0:3];
    logic [1:0]  r_deg;
    logic        r_closing;
    t_tval       r_t;
    logic        r_coord;
    logic [1:0]  r_lvl;
    logic [1:0]  r_idx;
    t_wide       r_w [0:3];
    t_coord      r_rx, r_ry;
    logic        r_ov;
    t_coord      r_ox, r_oy;
    logic        r_oe;

    t_step       step_clamped;
    t_tval       t_limit;
    logic        can_load;
    logic        out_load;
    logic        sample_last;
    t_wide       lerp_res;
    t_coord      m_x, m_y;
    logic signed [COORD_BITS:0] dx, dy;
    t_coord      cab_x, cab_y, cbc_x, cbc_y;

    always_comb begin
        if (r_cfg < STEP_MIN) begin
            step_clamped = STEP_MIN;
        end else if (r_cfg > STEP_MAX) begin
            step_clamped = STEP_MAX;
        end else begin
            step_clamped = r_cfg;
        end
    end

    assign t_limit     = T_ONE + t_tval'(r_step);
    assign can_load    = !r_ov || o_cv.ready;
    assign out_load    = can_load && (r_state == ST_EMIT || r_state == ST_EMIT_A ||
                                      r_state == ST_EMIT_B);
    assign sample_last = (r_t >= T_ONE) && (r_closing || !r_last);

    // control points: midpoints shifted by b minus the blended midpoint
    assign m_x   = t_coord'((COORD_BITS+1)'(r_mab_x) + (COORD_BITS+1)'(r_mbc_x) >>> 1);
    assign m_y   = t_coord'((COORD_BITS+1)'(r_mab_y) + (COORD_BITS+1)'(r_mbc_y) >>> 1);
    assign dx    = (COORD_BITS+1)'(r_new_x) - (COORD_BITS+1)'(m_x);
    assign dy    = (COORD_BITS+1)'(r_new_y) - (COORD_BITS+1)'(m_y);
    assign cab_x = sat_wide(t_wide'(r_mab_x) + t_wide'(dx));
    assign cab_y = sat_wide(t_wide'(r_mab_y) + t_wide'(dy));
    assign cbc_x = sat_wide(t_wide'(r_mbc_x) + t_wide'(dx));
    assign cbc_y = sat_wide(t_wide'(r_mbc_y) + t_wide'(dy));

    btct_lerp u_lerp (
        .i_clk (i_clk),
        .i_a   (r_w[r_idx]),
        .i_b   (r_w[r_idx + 2'd1]),
        .i_t   (r_t[T_BITS-2:0]),
        .o_res (lerp_res)
    );

    assign i_pt.ready  = (r_state == ST_IDLE);
    assign o_cv.valid  = r_ov;
    assign o_cv.curve_x = r_ox;
    assign o_cv.curve_y = r_oy;
    assign o_cv.run_end = r_oe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ps    <= 2'd0;
            r_cfg   <= STEP_RST;
            r_ov    <= 1'b0;
            r_old_x <= '0; r_old_y <= '0;
            r_new_x <= '0; r_new_y <= '0;
            r_car_x <= '0; r_car_y <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (r_ov && o_cv.ready && !out_load) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_pt.valid) begin
                        r_in_x <= i_pt.point_x;
                        r_in_y <= i_pt.point_y;
                        r_last <= i_pt.last_point;
                        r_step <= step_clamped;
                        case (r_ps)
                            2'd0: begin
                                r_new_x <= i_pt.point_x;
                                r_new_y <= i_pt.point_y;
                                r_ps    <= i_pt.last_point ? 2'd0 : 2'd1;
                            end
                            2'd1: begin
                                r_old_x <= r_new_x;
                                r_old_y <= r_new_y;
                                r_new_x <= i_pt.point_x;
                                r_new_y <= i_pt.point_y;
                                if (i_pt.last_point) begin
                                    r_ps    <= 2'd0;
                                    r_state <= ST_EMIT_A;
                                end else begin
                                    r_ps <= 2'd2;
                                end
                            end
                            default: begin
                                r_state <= ST_CTL1;
                            end
                        endcase
                    end
                end
                ST_CTL1: begin
                    r_mab_x <= t_coord'((COORD_BITS+1)'(r_old_x) + (COORD_BITS+1)'(r_new_x) >>> 1);
                    r_mab_y <= t_coord'((COORD_BITS+1)'(r_old_y) + (COORD_BITS+1)'(r_new_y) >>> 1);
                    r_mbc_x <= t_coord'((COORD_BITS+1)'(r_new_x) + (COORD_BITS+1)'(r_in_x) >>> 1);
                    r_mbc_y <= t_coord'((COORD_BITS+1)'(r_new_y) + (COORD_BITS+1)'(r_in_y) >>> 1);
                    r_state <= ST_CTL2;
                end
                ST_CTL2: begin
                    r_cbc_x <= cbc_x;
                    r_cbc_y <= cbc_y;
                    r_cpx[0] <= r_old_x;
                    r_cpy[0] <= r_old_y;
                    if (r_ps == 2'd2) begin
                        r_cpx[1] <= cab_x;   r_cpy[1] <= cab_y;
                        r_cpx[2] <= r_new_x; r_cpy[2] <= r_new_y;
                        r_deg    <= 2'd2;
                    end else begin
                        r_cpx[1] <= r_car_x; r_cpy[1] <= r_car_y;
                        r_cpx[2] <= cab_x;   r_cpy[2] <= cab_y;
                        r_cpx[3] <= r_new_x; r_cpy[3] <= r_new_y;
                        r_deg    <= 2'd3;
                    end
                    r_closing <= 1'b0;
                    r_t       <= '0;
                    r_state   <= ST_SAMP;
                end
                ST_SAMP: begin
                    if (r_t < t_limit) begin
                        for (int i = 0; i < 4; i++) begin
                            r_w[i] <= t_wide'(r_cpx[i]);
                        end
                        r_coord <= 1'b0;
                        r_lvl   <= r_deg;
                        r_idx   <= 2'd0;
                        r_state <= ST_ISSUE;
                    end else begin
                        r_state <= ST_FIN;
                    end
                end
                ST_ISSUE: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    r_state <= ST_WB;
                end
                ST_WB: begin
                    if (r_idx + 2'd1 < r_lvl) begin
                        r_w[r_idx] <= lerp_res;
                        r_idx   <= r_idx + 2'd1;
                        r_state <= ST_ISSUE;
                    end else if (r_lvl > 2'd1) begin
                        r_w[r_idx] <= lerp_res;
                        r_lvl   <= r_lvl - 2'd1;
                        r_idx   <= 2'd0;
                        r_state <= ST_ISSUE;
                    end else if (!r_coord) begin
                        r_rx <= sat_wide(lerp_res);
                        for (int i = 0; i < 4; i++) begin
                            r_w[i] <= t_wide'(r_cpy[i]);
                        end
                        r_coord <= 1'b1;
                        r_lvl   <= r_deg;
                        r_idx   <= 2'd0;
                        r_state <= ST_ISSUE;
                    end else begin
                        r_ry    <= sat_wide(lerp_res);
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (can_load) begin
                        r_ov    <= 1'b1;
                        r_ox    <= r_rx;
                        r_oy    <= r_ry;
                        r_oe    <= sample_last;
                        r_t     <= r_t + t_tval'(r_step);
                        r_state <= ST_SAMP;
                    end
                end
                ST_FIN: begin
                    if (!r_closing) begin
                        r_car_x <= r_cbc_x; r_car_y <= r_cbc_y;
                        r_old_x <= r_new_x; r_old_y <= r_new_y;
                        r_new_x <= r_in_x;  r_new_y <= r_in_y;
                        r_ps    <= r_last ? 2'd0 : 2'd3;
                        if (r_last) begin
                            // closing quadratic to the final point
                            r_cpx[0] <= r_new_x; r_cpy[0] <= r_new_y;
                            r_cpx[1] <= r_cbc_x; r_cpy[1] <= r_cbc_y;
                            r_cpx[2] <= r_in_x;  r_cpy[2] <= r_in_y;
                            r_deg     <= 2'd2;
                            r_closing <= 1'b1;
                            r_t       <= '0;
                            r_state   <= ST_SAMP;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_EMIT_A: begin
                    if (can_load) begin
                        r_ov    <= 1'b1;
                        r_ox    <= r_old_x;
                        r_oy    <= r_old_y;
                        r_oe    <= 1'b0;
                        r_state <= ST_EMIT_B;
                    end
                end
                ST_EMIT_B: begin
                    if (can_load) begin
                        r_ov    <= 1'b1;
                        r_ox    <= r_new_x;
                        r_oy    <= r_new_y;
                        r_oe    <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_idx_in_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ISSUE) |-> (r_idx < r_lvl))
        else $error("lerp index beyond level");

    a_deg_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ISSUE) |-> (r_deg == 2'd2 || r_deg == 2'd3))
        else $error("bad curve degree");

    a_t_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_t < t_limit))
        else $error("sample beyond curve end");

    a_pair_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT_B) |-> (r_ps == 2'd0))
        else $error("two-point curve did not restart");

endmodule

@@ src/btct_lerp.sv @@
// ----------------------------------------------------------------------------
// btct_lerp
// Shared two-stage lerp unit: res = a + floor((b - a) * t / 2^frac).
// ----------------------------------------------------------------------------
module btct_lerp (
    input  logic                              i_clk,
    input  logic signed [btct_pkg::WIDE_BITS-1:0] i_a,
    input  logic signed [btct_pkg::WIDE_BITS-1:0] i_b,
    input  logic [btct_pkg::T_BITS-2:0]       i_t,
    output logic signed [btct_pkg::WIDE_BITS-1:0] o_res
);
    import btct_pkg::*;

    localparam int PROD_BITS = WIDE_BITS + T_BITS;

    logic signed [WIDE_BITS:0]   diff;
    logic signed [T_BITS-1:0]    t_s;
    logic signed [PROD_BITS-1:0] prod;
    logic signed [PROD_BITS-1:0] r_prod;
    t_wide                       r_a;
    t_wide                       r_res;

    assign diff = {i_b[WIDE_BITS-1], i_b} - {i_a[WIDE_BITS-1], i_a};
    assign t_s  = $signed({1'b0, i_t});
    assign prod = PROD_BITS'(diff) * PROD_BITS'(t_s);

    always_ff @(posedge i_clk) begin
        r_a    <= i_a;
        r_prod <= prod;
        // arithmetic shift gives the floor
        r_res  <= r_a + t_wide'(r_prod >>> STEP_FRAC_BITS);
    end

    assign o_res = r_res;

endmodule
